// ===== design/pfl_pkg.sv =====
package pfl_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_RANGE = 2'd2;

  // result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_EMPTY   = 2'd1;
  localparam logic [1:0] STS_BADADDR = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  // configuration register indexes
  localparam logic CFG_KERNEL_END = 1'b0;
  localparam logic CFG_PHYS_TOP   = 1'b1;

  localparam logic [31:0] PHYS_TOP_RESET = 32'h8800_0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RANGE,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic op_alloc;
    logic op_free;
    logic op_bad;
    logic op_range;
    logic range_step;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_stop;
  } dp_sts_t;

endpackage

// ===== design/pfl_req_if.sv =====
interface pfl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] address;
  logic [31:0] range_end;

  modport source (output valid, output cmd, output address, output range_end, input ready);
  modport sink   (input valid, input cmd, input address, input range_end, output ready);
endinterface

// ===== design/pfl_rsp_if.sv =====
interface pfl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] page_addr;
  logic [15:0] free_pages;

  modport source (output valid, output status, output page_addr, output free_pages,
                  input ready);
  modport sink   (input valid, input status, input page_addr, input free_pages,
                  output ready);
endinterface

// ===== design/pfl_ctrl.sv =====
module pfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  pfl_pkg::dp_sts_t  sts,
  output pfl_pkg::dp_cmd_t  cmd
);
  import pfl_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_ALLOC: begin
              cmd.op_alloc = 1'b1;
              state_nxt    = S_FINISH;
            end
            CMD_FREE: begin
              cmd.op_free = 1'b1;
              state_nxt   = S_FINISH;
            end
            CMD_RANGE: begin
              cmd.op_range = 1'b1;
              state_nxt    = S_RANGE;
            end
            default: begin
              cmd.op_bad = 1'b1;
              state_nxt  = S_FINISH;
            end
          endcase
        end
      end
      S_RANGE: begin
        cmd.range_step = 1'b1;
        if (sts.range_stop) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/pfl_datapath.sv =====
module pfl_datapath #(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 32768,
  parameter int ADDR_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic [31:0]       address,
  input  logic [31:0]       range_end,
  input  pfl_pkg::dp_cmd_t  cmd,
  output pfl_pkg::dp_sts_t  sts,
  output logic [1:0]        out_status,
  output logic [31:0]       out_page_addr,
  output logic [15:0]       out_free_pages
);
  import pfl_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int AW         = (ADDR_BITS >= 32) ? 32 : ADDR_BITS;
  localparam int PN_BITS    = AW - PAGE_SHIFT;
  localparam int IDX_BITS   = $clog2(MAX_PAGES);
  localparam int CNT_BITS   = $clog2(MAX_PAGES + 1);
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [33:0] PAGE_W  = 34'(PAGE_BYTES);
  localparam logic [33:0] PAGE_M1 = 34'(PAGE_BYTES - 1);
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_PAGES);
  localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

  logic [PN_BITS-1:0] stack_mem [MAX_PAGES];

  logic [31:0]         kernel_end_r, phys_top_r;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [PN_BITS-1:0]  rd_data_r;
  logic [33:0]         p_r;
  logic [31:0]         rend_r;
  logic [1:0]          status_r, status_nxt;
  logic                hit_r, hit_nxt;

  logic [31:0]         addr_m, rend_m;
  logic [33:0]         sum_up, p_first, p_end;
  logic [CNT_BITS-1:0] cnt_m1;
  logic                full, empty, free_bad, bound_stop, step_bad, range_stop;
  logic                push_en, pop_en;
  logic [PN_BITS-1:0]  push_pn;

  function automatic logic addr_bad(input logic [33:0] a, input logic [31:0] ke,
                                    input logic [31:0] pt);
    return (a[PAGE_SHIFT-1:0] != '0) || (a < {2'b00, ke}) || (a >= {2'b00, pt});
  endfunction

  assign addr_m   = address & ADDR_MASK;
  assign rend_m   = range_end & ADDR_MASK;
  assign full     = (count_r >= CNT_MAX);
  assign empty    = (count_r == '0);
  assign cnt_m1   = count_r - CNT_ONE;
  assign free_bad = addr_bad({2'b00, addr_m}, kernel_end_r, phys_top_r);

  // round start up to a page, no wrap
  assign sum_up  = {2'b00, addr_m} + PAGE_M1;
  assign p_first = {sum_up[33:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

  assign p_end      = p_r + PAGE_W;
  assign bound_stop = (p_end > {2'b00, rend_r});
  assign step_bad   = addr_bad(p_r, kernel_end_r, phys_top_r);
  assign range_stop = bound_stop || step_bad || full;
  assign sts.range_stop = range_stop;

  assign pop_en  = cmd.op_alloc && !empty;
  assign push_en = (cmd.op_free && !free_bad && !full) || (cmd.range_step && !range_stop);
  assign push_pn = cmd.op_free ? addr_m[AW-1:PAGE_SHIFT] : p_r[AW-1:PAGE_SHIFT];

  always_comb begin
    count_nxt = count_r;
    if (push_en) begin
      count_nxt = count_r + CNT_ONE;
    end else if (pop_en) begin
      count_nxt = cnt_m1;
    end
  end

  always_comb begin
    status_nxt = status_r;
    hit_nxt    = hit_r;
    if (cmd.op_alloc) begin
      status_nxt = empty ? STS_EMPTY : STS_OK;
      hit_nxt    = !empty;
    end else if (cmd.op_free) begin
      status_nxt = free_bad ? STS_BADADDR : (full ? STS_FULL : STS_OK);
      hit_nxt    = 1'b0;
    end else if (cmd.op_bad) begin
      status_nxt = STS_BADADDR;
      hit_nxt    = 1'b0;
    end else if (cmd.op_range) begin
      status_nxt = STS_OK;
      hit_nxt    = 1'b0;
    end else if (cmd.range_step && range_stop) begin
      // loop bound wins over the page check, which wins over full
      if (bound_stop) begin
        status_nxt = STS_OK;
      end else if (step_bad) begin
        status_nxt = STS_BADADDR;
      end else begin
        status_nxt = STS_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_end_r <= '0;
      phys_top_r   <= PHYS_TOP_RESET;
      count_r      <= '0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_KERNEL_END: kernel_end_r <= cfg_wdata;
          CFG_PHYS_TOP:   phys_top_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // stack memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[count_r[IDX_BITS-1:0]] <= push_pn;
    end
    if (pop_en) begin
      rd_data_r <= stack_mem[cnt_m1[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    if (cmd.op_range) begin
      p_r    <= p_first;
      rend_r <= rend_m;
    end else if (cmd.range_step) begin
      p_r <= p_end;
    end
    if (cmd.out_load) begin
      out_status     <= status_r;
      out_page_addr  <= hit_r ? 32'({rd_data_r, {PAGE_SHIFT{1'b0}}}) : 32'd0;
      out_free_pages <= 16'(count_r);
    end
  end

endmodule

// ===== design/page_free_list_allocator.sv =====
// Channel   Dir   Word contents                        Handshake
// in_if     in    cmd[1:0] address[31:0] range_end[31:0]  valid/ready
// out_if    out   status[1:0] page_addr[31:0] free_pages[15:0]  valid/ready
// cfg_*     in    cfg_index selects register, cfg_wdata[31:0]  cfg_we, no wait
//
// Alloc, free and unknown commands: accept, then result load once the output
// slot frees (alloc reads the stack memory's registered read port in between).
// A range add makes one stack write per cycle per page, then loads its result.
// Synchronous active-low reset empties the stack by clearing the count only;
// the memory itself is not swept, so there is no clearing pass.
// A stalled output holds its word; a new input word is taken while it waits.
module page_free_list_allocator #(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 32768,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  pfl_req_if.sink     in_if,
  pfl_rsp_if.source   out_if,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import pfl_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // controller: accept in IDLE, walk range pages, load result when slot frees
  pfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_cmd    (in_if.cmd),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // datapath: config regs, stack memory, count, range walker, output register
  pfl_datapath #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_PAGES  (MAX_PAGES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .address        (in_if.address),
    .range_end      (in_if.range_end),
    .cmd            (dp_cmd),
    .sts            (dp_sts),
    .out_status     (out_if.status),
    .out_page_addr  (out_if.page_addr),
    .out_free_pages (out_if.free_pages)
  );

endmodule

// ===== design/pfl_checker.sv =====
module pfl_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_page_addr,
  input logic [15:0] out_free_pages
);

  // one word at a time: ready drops right after an accept
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous word in flight");

  // controller comes out of reset ready for a word
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_status) && $stable(out_page_addr) && $stable(out_free_pages)))
    else $error("output word changed while stalled");

endmodule

bind page_free_list_allocator pfl_assertions u_pfl_assertions (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_status     (out_if.status),
  .out_page_addr  (out_if.page_addr),
  .out_free_pages (out_if.free_pages)
);
